/* rtl/gcdng_pkg.sv */
// ----------------------------------------------------------------------------
// Digital net generator package
// Shared opcodes, register indexes, sequencer states, cell controls and the
// trailing-zero count used to pick the generating column.
// ----------------------------------------------------------------------------
package gcdng_pkg;

	// Opcodes carried with each input transfer.
	typedef enum logic [2:0] {
		OP_LOAD_COL   = 3'd0,
		OP_LOAD_SHIFT = 3'd1,
		OP_RESTART    = 3'd2,
		OP_ADVANCE    = 3'd3,
		OP_EMIT       = 3'd4
	} opcode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_NATURAL_ORDER  = 2'd0,
		CFG_ACTIVE_DIMS    = 2'd1,
		CFG_ACTIVE_COLUMNS = 2'd2,
		CFG_START_INDEX    = 2'd3
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_APPLY,
		ST_EMIT
	} state_t;

	// Controls broadcast from the sequencer to every cell.
	typedef struct packed {
		logic restart;
		logic load_col;
		logic load_shift;
		logic rd_en;
		logic apply;
		logic capture;
		logic exhaust;
		logic shift;
	} cell_ctrl_t;

	localparam int unsigned IN_TDATA_W  = 80;
	localparam int unsigned IN_TUSER_W  = 3;
	localparam int unsigned OUT_TDATA_W = 96;
	localparam int unsigned OUT_TUSER_W = 5;
	localparam int unsigned COORD_W     = 64;
	localparam int unsigned POS_W       = 32;
	localparam int unsigned K_W         = 33;

	// Trailing-zero count of a nonzero 32-bit word, by halving.
	function automatic logic [4:0] ctz32(input logic [31:0] v);
		logic [31:0] x;
		logic [4:0]  n;
		x = v;
		n = '0;
		if (x[15:0] == 16'h0) begin
			n[4] = 1'b1;
			x = x >> 16;
		end
		if (x[7:0] == 8'h0) begin
			n[3] = 1'b1;
			x = x >> 8;
		end
		if (x[3:0] == 4'h0) begin
			n[2] = 1'b1;
			x = x >> 4;
		end
		if (x[1:0] == 2'h0) begin
			n[1] = 1'b1;
			x = x >> 2;
		end
		if (x[0] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

/* rtl/gcdng_cell.sv */
// ----------------------------------------------------------------------------
// Digital net dimension cell
// Holds one dimension's point word, digital shift and generating columns,
// applies the Gray-code update and forms one link of the result chain.
// ----------------------------------------------------------------------------
module gcdng_cell #(
	parameter int unsigned WORD_BITS = 64,
	parameter int unsigned COLUMNS   = 32,
	parameter int unsigned CIDX_W    = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gcdng_pkg::cell_ctrl_t       ctl,
	input  logic                        sel,
	input  logic                        active,
	input  logic [CIDX_W-1:0]           wr_addr,
	input  logic [CIDX_W-1:0]           rd_addr,
	input  logic [WORD_BITS-1:0]        data,
	input  logic [gcdng_pkg::COORD_W-1:0] chain_in,
	output logic [gcdng_pkg::COORD_W-1:0] chain_out
);

	logic [WORD_BITS-1:0]          col_mem [COLUMNS];
	logic [WORD_BITS-1:0]          col_rd_q;
	logic [WORD_BITS-1:0]          point_q;
	logic [WORD_BITS-1:0]          shift_q;
	logic [gcdng_pkg::COORD_W-1:0] chain_q;
	logic [gcdng_pkg::COORD_W-1:0] coord;

	// Column memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.load_col && sel) begin
			col_mem[wr_addr] <= data;
		end
		if (ctl.rd_en) begin
			col_rd_q <= col_mem[rd_addr];
		end
	end

	// Point word: cleared on restart, XORed with the selected column on update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q <= '0;
		end else if (ctl.restart) begin
			point_q <= '0;
		end else if (ctl.apply && active) begin
			point_q <= point_q ^ col_rd_q;
		end
	end

	// Digital shift word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (ctl.load_shift && sel) begin
			shift_q <= data;
		end
	end

	// Shifted point as a left-aligned binary fraction.
	assign coord = gcdng_pkg::COORD_W'(point_q ^ shift_q) << (gcdng_pkg::COORD_W - WORD_BITS);

	// Result chain link: load in parallel, then pass toward cell zero.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			chain_q <= ctl.exhaust ? '0 : coord;
		end else if (ctl.shift) begin
			chain_q <= chain_in;
		end
	end

	assign chain_out = chain_q;

endmodule

/* rtl/gcdng_seq.sv */
// ----------------------------------------------------------------------------
// Digital net sequencer
// Configuration registers, point counter, exhaustion check, column choice,
// output position and the result drain count.
// ----------------------------------------------------------------------------
module gcdng_seq #(
	parameter int unsigned DIMS    = 16,
	parameter int unsigned COLUMNS = 32,
	parameter int unsigned CIDX_W  = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input side
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    opcode,
	input  logic [4:0]                    column_index,
	// Configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	// Cell controls
	output gcdng_pkg::cell_ctrl_t         ctl,
	output logic [CIDX_W-1:0]             rd_addr,
	output logic [4:0]                    nd,
	// Result side
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [3:0]                    out_dim,
	output logic [gcdng_pkg::POS_W-1:0]   out_pos,
	output logic                          out_exhausted,
	output logic                          out_last
);

	gcdng_pkg::state_t            state_q, state_d;
	logic                         natural_q;
	logic [4:0]                   act_dims_q;
	logic [5:0]                   act_cols_q;
	logic [gcdng_pkg::POS_W-1:0]  start_q;
	logic [gcdng_pkg::K_W-1:0]    k_q;
	logic                         emit_q;
	logic                         done_q;
	logic                         upd_q;
	logic [gcdng_pkg::POS_W-1:0]  pos_q;
	logic [4:0]                   nd_q;
	logic [4:0]                   out_cnt_q;
	logic [3:0]                   out_dim_q;
	logic [gcdng_pkg::POS_W-1:0]  out_pos_q;
	logic                         out_exh_q;
	logic                         accept;
	logic                         drain;
	logic [4:0]                   nd_clamp;
	logic [5:0]                   cols_clamp;
	logic [gcdng_pkg::K_W-1:0]    k_low_mask;
	logic                         done;
	logic [4:0]                   ctz;
	logic [gcdng_pkg::POS_W-1:0]  order_pos;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign drain     = out_valid && out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			natural_q  <= 1'b0;
			act_dims_q <= 5'd16;
			act_cols_q <= 6'd32;
			start_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gcdng_pkg::CFG_NATURAL_ORDER:  natural_q  <= cfg_data[0];
				gcdng_pkg::CFG_ACTIVE_DIMS:    act_dims_q <= cfg_data[4:0];
				gcdng_pkg::CFG_ACTIVE_COLUMNS: act_cols_q <= cfg_data[5:0];
				gcdng_pkg::CFG_START_INDEX:    start_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the active dimension and column counts to the built sizes.
	always_comb begin
		if (act_dims_q == 5'd0) begin
			nd_clamp = 5'd1;
		end else if ({2'b00, act_dims_q} > 7'(DIMS)) begin
			nd_clamp = 5'(DIMS);
		end else begin
			nd_clamp = act_dims_q;
		end
		if (act_cols_q == 6'd0) begin
			cols_clamp = 6'd1;
		end else if ({1'b0, act_cols_q} > 7'(COLUMNS)) begin
			cols_clamp = 6'(COLUMNS);
		end else begin
			cols_clamp = act_cols_q;
		end
	end

	// Exhaustion check, column choice and output position from the counter.
	assign k_low_mask = (gcdng_pkg::K_W'(1) << cols_clamp) - gcdng_pkg::K_W'(1);
	assign done       = |(k_q & ~k_low_mask);
	assign ctz        = gcdng_pkg::ctz32(k_q[31:0]);
	assign order_pos  = natural_q ? (k_q[31:0] ^ k_q[32:1]) : k_q[31:0];
	assign rd_addr    = ctz[CIDX_W-1:0];

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcdng_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and cell controls.
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		ctl            = '0;
		ctl.shift      = drain;
		ctl.exhaust    = done_q;
		case (state_q)
			gcdng_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					case (opcode)
						gcdng_pkg::OP_LOAD_COL: begin
							ctl.load_col = ({1'b0, column_index} < 6'(COLUMNS));
						end
						gcdng_pkg::OP_LOAD_SHIFT: ctl.load_shift = 1'b1;
						gcdng_pkg::OP_RESTART:    ctl.restart    = 1'b1;
						gcdng_pkg::OP_ADVANCE,
						gcdng_pkg::OP_EMIT:       state_d        = gcdng_pkg::ST_FIND;
						default: ;
					endcase
				end
			end
			gcdng_pkg::ST_FIND: begin
				ctl.rd_en = 1'b1;
				state_d   = gcdng_pkg::ST_APPLY;
			end
			gcdng_pkg::ST_APPLY: begin
				ctl.apply = upd_q;
				state_d   = emit_q ? gcdng_pkg::ST_EMIT : gcdng_pkg::ST_IDLE;
			end
			gcdng_pkg::ST_EMIT: begin
				if (out_cnt_q == 5'd0) begin
					ctl.capture = 1'b1;
					state_d     = gcdng_pkg::ST_IDLE;
				end
			end
			default: state_d = gcdng_pkg::ST_IDLE;
		endcase
	end

	// Per-item working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
			nd_q   <= 5'd1;
			done_q <= 1'b0;
			upd_q  <= 1'b0;
		end else begin
			if (accept) begin
				emit_q <= (opcode == gcdng_pkg::OP_EMIT);
				nd_q   <= nd_clamp;
			end
			if (state_q == gcdng_pkg::ST_FIND) begin
				done_q <= done;
				upd_q  <= !done && (k_q != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gcdng_pkg::ST_FIND) begin
			pos_q <= order_pos - start_q;
		end
	end

	// Point counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (ctl.restart) begin
			k_q <= '0;
		end else if (state_q == gcdng_pkg::ST_APPLY && !done_q) begin
			k_q <= k_q + gcdng_pkg::K_W'(1);
		end
	end

	// Result drain count and per-result side fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
			out_dim_q <= '0;
			out_exh_q <= 1'b0;
		end else if (ctl.capture) begin
			out_cnt_q <= nd_q;
			out_dim_q <= '0;
			out_exh_q <= done_q;
		end else if (drain) begin
			out_cnt_q <= out_cnt_q - 5'd1;
			out_dim_q <= out_dim_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			out_pos_q <= done_q ? '0 : pos_q;
		end
	end

	assign nd            = nd_q;
	assign out_valid     = (out_cnt_q != 5'd0);
	assign out_last      = (out_cnt_q == 5'd1);
	assign out_dim       = out_dim_q;
	assign out_pos       = out_pos_q;
	assign out_exhausted = out_exh_q;

endmodule

/* rtl/gray_code_digital_net_generator_top.sv */
// ----------------------------------------------------------------------------
// Gray-code digital net generator
// Base-2 digital net points by the Antonov-Saleev update, one cell per
// dimension in a chain that also shifts the results out.
// ----------------------------------------------------------------------------
// A load, restart or unused opcode is acted on as the idle state takes the
// transfer. An advance takes the transfer in the idle state, then checks
// exhaustion and finds the trailing-zero column while every cell reads that
// column from its own column memory, then XORs it into the points. An emit
// adds a state that loads the cell chain in parallel; the chain then gives one
// coordinate per active dimension in each cycle the output side takes one,
// dimension zero first, and the next emit loads the chain only once it has
// drained. The input side is ready whenever the sequencer is idle, also while
// results are still draining.
module gray_code_digital_net_generator_top #(
	parameter int unsigned DIMS      = 16,
	parameter int unsigned COLUMNS   = 32,
	parameter int unsigned WORD_BITS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// dim_index[3:0], column_index[8:4], data_word[72:9], zero pad [79:73]
	input  logic [gcdng_pkg::IN_TDATA_W-1:0]    s_tdata,
	// opcode[2:0]
	input  logic [gcdng_pkg::IN_TUSER_W-1:0]    s_tuser,
	// Result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// coordinate[63:0], position[95:64]
	output logic [gcdng_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// dimension[3:0], exhausted[4]
	output logic [gcdng_pkg::OUT_TUSER_W-1:0]   m_tuser,
	output logic                                m_tlast,
	// Configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [31:0]                         cfg_data
);

	localparam int unsigned CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	gcdng_pkg::cell_ctrl_t          ctl;
	logic [CIDX_W-1:0]              rd_addr;
	logic [4:0]                     nd;
	logic [3:0]                     out_dim;
	logic [gcdng_pkg::POS_W-1:0]    out_pos;
	logic                           out_exhausted;
	logic [gcdng_pkg::COORD_W-1:0]  chain [DIMS+1];
	logic [3:0]                     in_dim;
	logic [4:0]                     in_col;
	logic [WORD_BITS-1:0]           in_word;

	assign in_dim  = s_tdata[3:0];
	assign in_col  = s_tdata[8:4];
	assign in_word = s_tdata[9 +: WORD_BITS];

	// Sequencer and configuration.
	gcdng_seq #(
		.DIMS    (DIMS),
		.COLUMNS (COLUMNS),
		.CIDX_W  (CIDX_W)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.opcode        (s_tuser[2:0]),
		.column_index  (in_col),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.ctl           (ctl),
		.rd_addr       (rd_addr),
		.nd            (nd),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_dim       (out_dim),
		.out_pos       (out_pos),
		.out_exhausted (out_exhausted),
		.out_last      (m_tlast)
	);

	// The cell past the end of the chain feeds zeros.
	assign chain[DIMS] = '0;

	// One cell per dimension.
	for (genvar j = 0; j < DIMS; j++) begin : g_cell
		logic sel;
		logic active;

		assign sel    = (7'(j) == {3'b000, in_dim});
		assign active = (7'(j) < {2'b00, nd});

		gcdng_cell #(
			.WORD_BITS (WORD_BITS),
			.COLUMNS   (COLUMNS),
			.CIDX_W    (CIDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.sel       (sel),
			.active    (active),
			.wr_addr   (in_col[CIDX_W-1:0]),
			.rd_addr   (rd_addr),
			.data      (in_word),
			.chain_in  (chain[j+1]),
			.chain_out (chain[j])
		);
	end

	assign m_tdata = {out_pos, chain[0]};
	assign m_tuser = {out_exhausted, out_dim};

endmodule
